// ----- src/rdf_pkg.sv -----
// Package with the beat types, mode codes, character constants and state type of the formatter.
package rdf_pkg;

	// Mode codes carried in the op field.
	localparam logic [1:0] OP_UDEC = 2'd0;
	localparam logic [1:0] OP_SDEC = 2'd1;
	localparam logic [1:0] OP_HEX  = 2'd2;
	localparam logic [1:0] OP_BIN  = 2'd3;

	// ASCII codes used by the formatter.
	localparam logic [6:0] CH_ZERO  = 7'h30;
	localparam logic [6:0] CH_ALPHA = 7'h41;
	localparam logic [6:0] CH_PLUS  = 7'h2B;
	localparam logic [6:0] CH_MINUS = 7'h2D;

	// Digit count limits per base.
	localparam logic [5:0] LIM_DEC = 6'd10;
	localparam logic [5:0] LIM_HEX = 6'd8;
	localparam logic [5:0] LIM_BIN = 6'd32;

	// Width of the digit shift register: ten BCD digits.
	localparam int DIG_W = 40;

	// One request beat.
	typedef struct packed {
		logic [1:0]  op;
		logic [31:0] number;
		logic [5:0]  digit_count;
		logic [2:0]  line;
		logic [4:0]  start_column;
	} rdf_req_t;

	// One character beat.
	typedef struct packed {
		logic [6:0] char_code;
		logic [2:0] line_out;
		logic [5:0] column_out;
		logic       last;
	} rdf_rsp_t;

	// Control into the BCD converter.
	typedef struct packed {
		logic        start;
		logic [31:0] value;
	} rdf_dab_ctl_t;

	// Status out of the BCD converter.
	typedef struct packed {
		logic             busy;
		logic [DIG_W-1:0] bcd;
	} rdf_dab_sts_t;

	// Sequencer states.
	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SIGN,
		ST_CONV,
		ST_ALIGN,
		ST_EMIT
	} rdf_state_t;

	// Hex digit to upper-case ASCII.
	function automatic logic [6:0] hex_char(input logic [3:0] d);
		logic [6:0] c;
		if (d < 4'd10) begin
			c = CH_ZERO + {3'b000, d};
		end else begin
			c = CH_ALPHA + {3'b000, d} - 7'd10;
		end
		return c;
	endfunction

endpackage

// ----- src/radix_digit_formatter_unit.sv -----
// Top level of the formatter: request capture, digit alignment and character emission.
// Decimal modes run a bit-serial BCD conversion before the digits are aligned and emitted.
// Throughput: one character per cycle while emitting and the output register is free; a new
// number is taken once the last character sits in the output register.
// Reset: arst_n asynchronously clears the sequencer, converter and output valid.
module radix_digit_formatter_unit (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              req_valid,
	output logic              req_ready,
	input  rdf_pkg::rdf_req_t req,
	output logic              rsp_valid,
	input  logic              rsp_ready,
	output rdf_pkg::rdf_rsp_t rsp
);

	rdf_pkg::rdf_state_t       state_q, state_d;
	rdf_pkg::rdf_dab_ctl_t     dab_ctl;
	rdf_pkg::rdf_dab_sts_t     dab_sts;
	rdf_pkg::rdf_rsp_t         rsp_q, emit_data;
	logic                      rsp_valid_q;
	logic                      accept, slot_free, emit, load_bcd, do_shift;
	logic [1:0]                mode_q;
	logic                      neg_q;
	logic [2:0]                line_q;
	logic [5:0]                col_q, cnt_q, skip_q;
	logic [5:0]                limit, cnt_sat;
	logic [rdf_pkg::DIG_W-1:0] dig_q;
	logic [31:0]               mag;
	logic                      is_dec;

	// BCD converter for the decimal modes.
	rdf_dabble u_dabble (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl    (dab_ctl),
		.sts    (dab_sts)
	);

	// Request decode: count saturation and magnitude of signed values.
	always_comb begin
		is_dec = (req.op == rdf_pkg::OP_UDEC) || (req.op == rdf_pkg::OP_SDEC);
		unique case (req.op)
			rdf_pkg::OP_HEX: limit = rdf_pkg::LIM_HEX;
			rdf_pkg::OP_BIN: limit = rdf_pkg::LIM_BIN;
			default:         limit = rdf_pkg::LIM_DEC;
		endcase
		cnt_sat = (req.digit_count > limit) ? limit : req.digit_count;
		if ((req.op == rdf_pkg::OP_SDEC) && req.number[31]) begin
			mag = ~req.number + 32'd1;
		end else begin
			mag = req.number;
		end
	end

	assign req_ready     = (state_q == rdf_pkg::ST_IDLE);
	assign accept        = req_valid && req_ready;
	assign slot_free     = !rsp_valid_q || rsp_ready;
	assign dab_ctl.start = accept && is_dec && (cnt_sat != 6'd0);
	assign dab_ctl.value = mag;

	// Sequencer: next state and the strobes for the datapath.
	always_comb begin
		state_d             = state_q;
		emit                = 1'b0;
		load_bcd            = 1'b0;
		do_shift            = 1'b0;
		emit_data.line_out  = line_q;
		emit_data.column_out = col_q;
		emit_data.char_code = rdf_pkg::hex_char(dig_q[rdf_pkg::DIG_W-1 -: 4]);
		emit_data.last      = (cnt_q == 6'd1);
		if (mode_q == rdf_pkg::OP_BIN) begin
			emit_data.char_code = rdf_pkg::CH_ZERO + {6'd0, dig_q[rdf_pkg::DIG_W-1]};
		end
		unique case (state_q)
			rdf_pkg::ST_IDLE: begin
				if (req_valid) begin
					if (req.op == rdf_pkg::OP_SDEC) begin
						state_d = rdf_pkg::ST_SIGN;
					end else if (cnt_sat == 6'd0) begin
						state_d = rdf_pkg::ST_IDLE;
					end else if (is_dec) begin
						state_d = rdf_pkg::ST_CONV;
					end else begin
						state_d = rdf_pkg::ST_ALIGN;
					end
				end
			end
			rdf_pkg::ST_SIGN: begin
				emit_data.char_code = neg_q ? rdf_pkg::CH_MINUS : rdf_pkg::CH_PLUS;
				emit_data.last      = (cnt_q == 6'd0);
				if (slot_free) begin
					emit    = 1'b1;
					state_d = (cnt_q == 6'd0) ? rdf_pkg::ST_IDLE : rdf_pkg::ST_CONV;
				end
			end
			rdf_pkg::ST_CONV: begin
				if (!dab_sts.busy) begin
					load_bcd = 1'b1;
					state_d  = rdf_pkg::ST_ALIGN;
				end
			end
			rdf_pkg::ST_ALIGN: begin
				if (skip_q == 6'd0) begin
					state_d = rdf_pkg::ST_EMIT;
				end else begin
					do_shift = 1'b1;
				end
			end
			rdf_pkg::ST_EMIT: begin
				if (slot_free) begin
					emit     = 1'b1;
					do_shift = 1'b1;
					if (cnt_q == 6'd1) begin
						state_d = rdf_pkg::ST_IDLE;
					end
				end
			end
			default: state_d = rdf_pkg::ST_IDLE;
		endcase
	end

	// State register and output valid.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= rdf_pkg::ST_IDLE;
			rsp_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (emit) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp_ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	// Item fields, digit shift register and counters.
	always_ff @(posedge clk) begin
		if (accept) begin
			mode_q <= req.op;
			neg_q  <= req.number[31];
			line_q <= req.line;
			col_q  <= {1'b0, req.start_column};
			cnt_q  <= cnt_sat;
			skip_q <= limit - cnt_sat;
			dig_q  <= {req.number, 8'd0};
		end else begin
			if (load_bcd) begin
				dig_q <= dab_sts.bcd;
			end else if (do_shift) begin
				if (mode_q == rdf_pkg::OP_BIN) begin
					dig_q <= {dig_q[rdf_pkg::DIG_W-2:0], 1'b0};
				end else begin
					dig_q <= {dig_q[rdf_pkg::DIG_W-5:0], 4'd0};
				end
			end
			if (state_q == rdf_pkg::ST_ALIGN && do_shift) begin
				skip_q <= skip_q - 6'd1;
			end
			if (emit) begin
				col_q <= col_q + 6'd1;
				if (state_q == rdf_pkg::ST_EMIT) begin
					cnt_q <= cnt_q - 6'd1;
				end
			end
		end
	end

	// Output register.
	always_ff @(posedge clk) begin
		if (emit) begin
			rsp_q <= emit_data;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

endmodule

// ----- src/rdf_dabble.sv -----
// Bit-serial binary to BCD converter using the shift-and-add-three method.
module rdf_dabble (
	input  logic                  clk,
	input  logic                  arst_n,
	input  rdf_pkg::rdf_dab_ctl_t ctl,
	output rdf_pkg::rdf_dab_sts_t sts
);

	logic                      busy_q;
	logic [4:0]                cnt_q;
	logic [31:0]               bin_q;
	logic [rdf_pkg::DIG_W-1:0] bcd_q;
	logic [rdf_pkg::DIG_W-1:0] adj;

	// Add three to every BCD digit that is five or more before the shift.
	always_comb begin
		for (int i = 0; i < rdf_pkg::DIG_W / 4; i++) begin
			if (bcd_q[i*4 +: 4] >= 4'd5) begin
				adj[i*4 +: 4] = bcd_q[i*4 +: 4] + 4'd3;
			end else begin
				adj[i*4 +: 4] = bcd_q[i*4 +: 4];
			end
		end
	end

	// Busy flag and bit counter: the counter runs down from 31 to zero, one shift per bit.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
		end else if (ctl.start) begin
			busy_q <= 1'b1;
			cnt_q  <= 5'd31;
		end else if (busy_q) begin
			cnt_q <= cnt_q - 5'd1;
			if (cnt_q == 5'd0) begin
				busy_q <= 1'b0;
			end
		end
	end

	// Shift one bit of the binary value into the BCD register per cycle.
	always_ff @(posedge clk) begin
		if (ctl.start) begin
			bin_q <= ctl.value;
			bcd_q <= '0;
		end else if (busy_q) begin
			bin_q <= {bin_q[30:0], 1'b0};
			bcd_q <= {adj[rdf_pkg::DIG_W-2:0], bin_q[31]};
		end
	end

	assign sts.busy = busy_q;
	assign sts.bcd  = bcd_q;

endmodule

// ----- src/rdf_checker.sv -----
// Port-level checker for the formatter and its bind to the top level.
module rdf_checker (
	input logic              clk,
	input logic              arst_n,
	input logic              req_valid,
	input logic              req_ready,
	input rdf_pkg::rdf_req_t req,
	input logic              rsp_valid,
	input logic              rsp_ready,
	input rdf_pkg::rdf_rsp_t rsp
);

	// A stalled character beat stays put.
	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp))
		else $error("character beat changed while stalled");

	// Every character is a sign, a decimal digit or an upper-case hex letter.
	a_char_set: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> (rsp.char_code == rdf_pkg::CH_PLUS) ||
			(rsp.char_code == rdf_pkg::CH_MINUS) ||
			(rsp.char_code >= 7'h30 && rsp.char_code <= 7'h39) ||
			(rsp.char_code >= 7'h41 && rsp.char_code <= 7'h46))
		else $error("character outside the digit set");

	// A request that yields characters leaves the block not ready in the cycle after it is taken.
	a_busy_after: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && req_ready &&
			(req.op == rdf_pkg::OP_SDEC || req.digit_count != 6'd0) |=> !req_ready)
		else $error("ready right after a request with characters");

	// While idle, a pending character can only be the final one of a number.
	a_idle_last: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && req_ready |-> rsp.last)
		else $error("idle with a non-final character pending");

endmodule

bind radix_digit_formatter_unit rdf_checker u_rdf_checker (.*);
